// ===== rtl/task_table_ready_queue_defines.svh =====
// assertion macros for the task table
`ifndef TASK_TABLE_READY_QUEUE_DEFINES_SVH
`define TASK_TABLE_READY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define TTRQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTRQ_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTRQ_ASSERT(label, clk, rst_n, prop, msg)
`define TTRQ_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/ttrq_pkg.sv =====
`default_nettype none
package ttrq_pkg;

    localparam logic [2:0] K_CREATE  = 3'd0;
    localparam logic [2:0] K_KILL    = 3'd1;
    localparam logic [2:0] K_EXIT    = 3'd2;
    localparam logic [2:0] K_SWITCH  = 3'd3;
    localparam logic [2:0] K_QUERY   = 3'd4;
    localparam logic [2:0] K_REQUEUE = 3'd5;

    localparam logic [2:0] S_OK      = 3'd0;
    localparam logic [2:0] S_FULL    = 3'd1;
    localparam logic [2:0] S_BADID   = 3'd2;
    localparam logic [2:0] S_NOTFND  = 3'd3;
    localparam logic [2:0] S_NORUN   = 3'd4;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_TERM  = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] pid;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_pid;
        logic        alive;
        logic [31:0] running_pid;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch command, clear scan
        logic scan;     // examine one slot
        logic act;      // apply the operation
        logic walk;     // one step of the queue walk
        logic finish;   // register the result
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic walk_need;
        logic walk_done;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/task_table_ready_queue.sv =====
`default_nettype none
// Task table with a FIFO ready queue.
// Issue a command word (kind, pid) by raising start while busy is low;
// the word is taken at that edge. Kinds: create, kill, exit running,
// switch, query alive, requeue running.
// One result word appears for exactly one cycle on o_rsp, marked by o_done;
// the receiver cannot stall and must take it in that cycle.
// Steps: the scan examines every slot, one slot per cycle, then the
// update is applied and the result is registered; kill or exit of a task
// queued behind the head of the ready queue also walks the queue links,
// one link per cycle, before the result register. busy stays high
// through the o_done cycle, so a new command is taken only after the
// result of the last one has been given.
// Reset (synchronous, active low) frees all slots, empties the queue,
// clears the running task and restarts identifiers at one.
module task_table_ready_queue #(
    parameter int NUM_SLOTS  = 16,
    parameter int IDENT_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire ttrq_pkg::t_cmd i_cmd,
    output logic                busy,
    output logic                o_done,
    output ttrq_pkg::t_rsp      o_rsp
);
    ttrq_pkg::t_ctl ctl;
    ttrq_pkg::t_sts sts;

    ttrq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_sts(sts),
        .o_ctl(ctl), .o_busy(busy), .o_done(o_done)
    );

    ttrq_dp #(.NUM_SLOTS(NUM_SLOTS), .IDENT_BITS(IDENT_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd), .i_ctl(ctl),
        .o_sts(sts), .o_rsp(o_rsp)
    );
endmodule
`default_nettype wire

// ===== rtl/ttrq_ctrl.sv =====
`default_nettype none
`include "task_table_ready_queue_defines.svh"
module ttrq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire ttrq_pkg::t_sts i_sts,
    output ttrq_pkg::t_ctl     o_ctl,
    output logic               o_busy,
    output logic               o_done
);
    typedef enum logic [5:0] {
        IDLE   = 6'b000001,
        SCAN   = 6'b000010,
        ACT    = 6'b000100,
        WALK   = 6'b001000,
        FIN    = 6'b010000,
        DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            IDLE: if (i_start) n_state = SCAN;
            SCAN: if (i_sts.scan_last) n_state = ACT;
            ACT:  n_state = i_sts.walk_need ? WALK : FIN;
            WALK: if (i_sts.walk_done) n_state = FIN;
            FIN:  n_state = DONE;
            DONE: n_state = IDLE;
            default: n_state = IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= IDLE;
        else r_state <= n_state;
    end

    // commands
    always_comb begin
        o_ctl.load   = (r_state == IDLE) && i_start;
        o_ctl.scan   = (r_state == SCAN);
        o_ctl.act    = (r_state == ACT);
        o_ctl.walk   = (r_state == WALK);
        o_ctl.finish = (r_state == FIN);
    end
    assign o_busy = (r_state != IDLE);
    assign o_done = (r_state == DONE);

    `TTRQ_ASSERT(a_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `TTRQ_ASSERT(a_start, i_clk, i_rst_n, o_ctl.load |=> (r_state == SCAN), "start lost")
    `TTRQ_ASSERT(a_done, i_clk, i_rst_n, o_done |=> !o_busy, "done not followed by idle")
endmodule
`default_nettype wire

// ===== rtl/ttrq_dp.sv =====
`default_nettype none
module ttrq_dp #(
    parameter int NUM_SLOTS  = 16,
    parameter int IDENT_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ttrq_pkg::t_cmd i_cmd,
    input  wire ttrq_pkg::t_ctl i_ctl,
    output ttrq_pkg::t_sts      o_sts,
    output ttrq_pkg::t_rsp      o_rsp
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [IDENT_BITS-1:0] IMAX = {IDENT_BITS{1'b1}};

    // slot table
    logic [1:0]            r_state [NUM_SLOTS];
    logic [IDENT_BITS-1:0] r_ident [NUM_SLOTS];
    logic [SW-1:0]         r_link  [NUM_SLOTS];
    logic                  r_queued[NUM_SLOTS];
    logic [SW-1:0]         r_head, r_tail, r_run;
    logic                  r_empty, r_run_v;
    logic [IDENT_BITS-1:0] r_next;

    // command and scan state
    logic [2:0]    r_kind;
    logic [31:0]   r_pid;
    logic [SW-1:0] r_idx;
    logic          r_found, r_alive;
    logic [SW-1:0] r_fslot;
    logic [2:0]    r_status;
    logic [IDENT_BITS-1:0] r_rpid;
    logic [SW-1:0] r_prev, r_target;
    logic [CW-1:0] r_steps;
    ttrq_pkg::t_rsp r_rsp;

    logic          pid_in, pid_hit, free_hit, alive_hit;
    logic [1:0]    cst;

    assign cst      = r_state[r_idx];
    assign pid_in   = (r_pid[31:0] <= 32'(IMAX));
    assign pid_hit  = pid_in && (r_ident[r_idx] == r_pid[IDENT_BITS-1:0]);
    assign free_hit = (cst == ttrq_pkg::ST_FREE) || (cst == ttrq_pkg::ST_TERM);
    assign alive_hit = ((cst == ttrq_pkg::ST_READY) || (cst == ttrq_pkg::ST_RUN)) && pid_hit;

    assign o_sts.scan_last = (32'(r_idx) == NUM_SLOTS - 1);

    // walk step signals
    logic [SW-1:0] cur;
    assign cur = r_link[r_prev];

    logic walk_need_c;
    logic [SW-1:0] ulink_s;
    logic          unlink_mid;

    always_comb begin
        logic [SW-1:0] s;
        s = r_fslot;
        if (r_kind == ttrq_pkg::K_EXIT) s = r_run;
        ulink_s = s;
        unlink_mid = r_queued[s] && !r_empty && (r_head != s);
    end

    always_comb begin
        walk_need_c = 1'b0;
        case (r_kind)
            ttrq_pkg::K_KILL:
                walk_need_c = pid_in_ok() && unlink_mid;
            ttrq_pkg::K_EXIT:
                walk_need_c = r_run_v && unlink_mid;
            default: walk_need_c = 1'b0;
        endcase
    end
    assign o_sts.walk_need = walk_need_c;
    assign o_sts.walk_done = (r_prev == r_tail) || (cur == r_target) ||
                             (32'(r_steps) >= NUM_SLOTS - 1);

    function automatic logic pid_in_ok();
        logic bad;
        bad = (r_pid == 32'd0) || !pid_in ||
              ((r_next != '0) && (r_pid[IDENT_BITS-1:0] >= r_next));
        return !bad && r_found && (r_state[r_fslot] != ttrq_pkg::ST_TERM);
    endfunction

    // table update
    always_ff @(posedge i_clk) begin
        logic [SW-1:0] s, hd, hd_nxt;
        logic          app_ok;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_state[k]  <= ttrq_pkg::ST_FREE;
                r_ident[k]  <= '0;
                r_queued[k] <= 1'b0;
            end
            r_head <= '0; r_tail <= '0; r_empty <= 1'b1;
            r_run <= '0; r_run_v <= 1'b0; r_next <= IDENT_BITS'(1);
            r_rsp <= '0;
        end else begin
            if (i_ctl.load) begin
                r_kind <= i_cmd.kind; r_pid <= i_cmd.pid;
                r_idx <= '0; r_found <= 1'b0; r_alive <= 1'b0;
                r_fslot <= '0; r_status <= ttrq_pkg::S_OK; r_rpid <= '0;
            end
            if (i_ctl.scan) begin
                if (!o_sts.scan_last) r_idx <= r_idx + 1'b1;
                if (alive_hit) r_alive <= 1'b1;
                if (!r_found) begin
                    if ((r_kind == ttrq_pkg::K_CREATE) && free_hit) begin
                        r_found <= 1'b1; r_fslot <= r_idx;
                    end
                    if ((r_kind == ttrq_pkg::K_KILL) && (cst != ttrq_pkg::ST_FREE) && pid_hit)
                    begin
                        r_found <= 1'b1; r_fslot <= r_idx;
                    end
                end
            end
            if (i_ctl.act) begin
                s = ulink_s;
                r_prev <= r_head; r_target <= s; r_steps <= '0;
                case (r_kind)
                    ttrq_pkg::K_CREATE: begin
                        if (!r_found || r_next == '0) r_status <= ttrq_pkg::S_FULL;
                        else begin
                            r_ident[r_fslot] <= r_next;
                            r_state[r_fslot] <= ttrq_pkg::ST_READY;
                            r_queued[r_fslot] <= 1'b1;
                            r_rpid <= r_next;
                            r_next <= r_next + 1'b1;
                            if (r_empty) r_head <= r_fslot;
                            else r_link[r_tail] <= r_fslot;
                            r_tail <= r_fslot; r_empty <= 1'b0;
                        end
                    end
                    ttrq_pkg::K_KILL, ttrq_pkg::K_EXIT: begin
                        if ((r_kind == ttrq_pkg::K_KILL) &&
                            ((r_pid == 32'd0) || !pid_in ||
                             ((r_next != '0) && (r_pid[IDENT_BITS-1:0] >= r_next))))
                            r_status <= ttrq_pkg::S_BADID;
                        else if ((r_kind == ttrq_pkg::K_KILL) &&
                                 (!r_found || r_state[r_fslot] == ttrq_pkg::ST_TERM))
                            r_status <= ttrq_pkg::S_NOTFND;
                        else if ((r_kind == ttrq_pkg::K_EXIT) && !r_run_v)
                            r_status <= ttrq_pkg::S_NORUN;
                        else begin
                            r_state[s] <= ttrq_pkg::ST_TERM;
                            if (r_run_v && r_run == s) r_run_v <= 1'b0;
                            if (r_queued[s] && !r_empty) begin
                                r_queued[s] <= 1'b0;
                                if (r_head == s) begin
                                    if (r_tail == s) r_empty <= 1'b1;
                                    else r_head <= r_link[s];
                                end
                            end
                        end
                    end
                    ttrq_pkg::K_SWITCH: begin
                        // append running task, then pop head
                        app_ok = r_run_v && !r_queued[r_run] &&
                                 (r_state[r_run] != ttrq_pkg::ST_TERM);
                        if (!r_run_v && r_empty) r_status <= ttrq_pkg::S_NORUN;
                        else if (r_empty && !app_ok) begin
                            r_state[r_run] <= ttrq_pkg::ST_RUN;
                            r_rpid <= r_ident[r_run];
                        end else begin
                            hd = r_empty ? r_run : r_head;
                            // successor of the head sees the append made in this cycle
                            hd_nxt = (app_ok && !r_empty && (hd == r_tail)) ? r_run
                                                                             : r_link[hd];
                            if (app_ok && !r_empty) begin
                                r_link[r_tail] <= r_run; r_tail <= r_run;
                                r_queued[r_run] <= 1'b1;
                            end
                            if (app_ok && r_empty) begin
                                r_tail <= r_run; r_head <= r_run;
                            end
                            // pop hd
                            if (hd == (app_ok ? r_run : r_tail)) r_empty <= 1'b1;
                            else begin
                                r_head <= hd_nxt; r_empty <= 1'b0;
                            end
                            r_queued[hd] <= 1'b0;
                            if (r_run_v && r_state[r_run] == ttrq_pkg::ST_RUN && hd != r_run)
                                r_state[r_run] <= ttrq_pkg::ST_READY;
                            r_state[hd] <= ttrq_pkg::ST_RUN;
                            r_run <= hd; r_run_v <= 1'b1;
                            r_rpid <= r_ident[hd];
                        end
                    end
                    ttrq_pkg::K_REQUEUE: begin
                        if (!r_run_v) r_status <= ttrq_pkg::S_NORUN;
                        else if (r_state[r_run] == ttrq_pkg::ST_RUN) begin
                            r_state[r_run] <= ttrq_pkg::ST_READY;
                            if (!r_queued[r_run]) begin
                                if (r_empty) r_head <= r_run;
                                else r_link[r_tail] <= r_run;
                                r_tail <= r_run; r_empty <= 1'b0;
                                r_queued[r_run] <= 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            // walk for unlink of a task queued behind the head of the queue
            if (i_ctl.walk) begin
                r_steps <= r_steps + 1'b1;
                if (r_prev != r_tail) begin
                    if (cur == r_target) begin
                        if (r_tail == r_target) r_tail <= r_prev;
                        else r_link[r_prev] <= r_link[r_target];
                    end else r_prev <= cur;
                end
            end
            if (i_ctl.finish) begin
                r_rsp.status      <= r_status;
                r_rsp.result_pid  <= 32'(r_rpid);
                r_rsp.alive       <= (r_kind == ttrq_pkg::K_QUERY) && r_alive;
                r_rsp.running_pid <= r_run_v ? 32'(r_ident[r_run]) : 32'd0;
            end
        end
    end

    assign o_rsp = r_rsp;
endmodule
`default_nettype wire

// ===== dv/tb_task_table_ready_queue.sv =====
`timescale 1ns / 1ps
module tb_task_table_ready_queue;
    import ttrq_pkg::*;

    localparam int NSLOT      = 16;
    localparam int WDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_cmd i_cmd = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    task_table_ready_queue u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_cmd  (i_cmd),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // scheduler state mirror
    logic [1:0]  m_state [NSLOT];
    logic [31:0] m_ident [NSLOT];
    logic [3:0]  m_link  [NSLOT];
    logic        m_queued[NSLOT];
    logic [3:0]  m_head, m_tail, m_run;
    logic        m_qempty, m_run_ok;
    logic [31:0] m_next;

    t_cmd cmd_q[$];
    t_rsp rsp_q[$];
    int   gap_q[$];
    int   n_err = 0;
    int   n_words = 0;
    int   n_done = 0;
    int   n_kind[8];

    function automatic void sched_reset();
        for (int i = 0; i < NSLOT; i++) begin
            m_state[i] = ST_FREE;
            m_ident[i] = '0;
            m_link[i] = '0;
            m_queued[i] = 1'b0;
        end
        m_head = '0;
        m_tail = '0;
        m_qempty = 1'b1;
        m_run = '0;
        m_run_ok = 1'b0;
        m_next = 32'd1;
    endfunction

    function automatic void ready_append(logic [3:0] s);
        if (m_queued[s] || m_state[s] == ST_TERM) return;
        if (m_qempty) begin
            m_head = s;
            m_qempty = 1'b0;
        end else begin
            m_link[m_tail] = s;
        end
        m_tail = s;
        m_queued[s] = 1'b1;
    endfunction

    function automatic logic ready_pop(output logic [3:0] s);
        s = m_head;
        if (m_qempty) return 1'b0;
        if (m_head == m_tail) m_qempty = 1'b1;
        else m_head = m_link[m_head];
        m_queued[s] = 1'b0;
        return 1'b1;
    endfunction

    function automatic void ready_unlink(logic [3:0] s);
        logic [3:0] prv, cur;
        if (!m_queued[s] || m_qempty) return;
        m_queued[s] = 1'b0;
        if (m_head == s) begin
            if (m_tail == s) m_qempty = 1'b1;
            else m_head = m_link[s];
            return;
        end
        prv = m_head;
        for (int n = 0; n < NSLOT && prv != m_tail; n++) begin
            cur = m_link[prv];
            if (cur == s) begin
                if (m_tail == s) m_tail = prv;
                else m_link[prv] = m_link[s];
                return;
            end
            prv = cur;
        end
    endfunction

    function automatic void slot_kill(logic [3:0] s);
        ready_unlink(s);
        m_state[s] = ST_TERM;
        if (m_run_ok && m_run == s) m_run_ok = 1'b0;
    endfunction

    // compute the response word for one command and update the mirror
    function automatic t_rsp sched_apply(t_cmd c);
        t_rsp r;
        int   hit;
        logic [3:0] s, p;
        r = '0;
        hit = -1;
        case (c.kind)
            K_CREATE: begin
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (m_state[i] == ST_FREE || m_state[i] == ST_TERM) hit = i;
                if (hit < 0 || m_next == 0) begin
                    r.status = S_FULL;
                end else begin
                    m_ident[hit] = m_next;
                    m_state[hit] = ST_READY;
                    m_queued[hit] = 1'b0;
                    r.result_pid = m_next;
                    m_next = m_next + 32'd1;
                    ready_append(hit[3:0]);
                end
            end
            K_KILL: begin
                if (c.pid == 0 || (m_next != 0 && c.pid >= m_next)) begin
                    r.status = S_BADID;
                end else begin
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (m_state[i] != ST_FREE && m_ident[i] == c.pid) hit = i;
                    if (hit < 0 || m_state[hit] == ST_TERM) r.status = S_NOTFND;
                    else slot_kill(hit[3:0]);
                end
            end
            K_EXIT: begin
                if (!m_run_ok) r.status = S_NORUN;
                else slot_kill(m_run);
            end
            K_SWITCH: begin
                if (m_run_ok) begin
                    s = m_run;
                    if (m_state[s] == ST_RUN) m_state[s] = ST_READY;
                    ready_append(s);
                    if (ready_pop(p)) begin
                        m_state[p] = ST_RUN;
                        m_run = p;
                    end else begin
                        m_state[s] = ST_RUN;
                    end
                    r.result_pid = m_ident[m_run];
                end else if (ready_pop(p)) begin
                    m_state[p] = ST_RUN;
                    m_run = p;
                    m_run_ok = 1'b1;
                    r.result_pid = m_ident[p];
                end else begin
                    r.status = S_NORUN;
                end
            end
            K_QUERY: begin
                for (int i = 0; i < NSLOT; i++)
                    if ((m_state[i] == ST_READY || m_state[i] == ST_RUN)
                        && m_ident[i] == c.pid) r.alive = 1'b1;
            end
            K_REQUEUE: begin
                if (!m_run_ok) begin
                    r.status = S_NORUN;
                end else if (m_state[m_run] == ST_RUN) begin
                    m_state[m_run] = ST_READY;
                    ready_append(m_run);
                end
            end
            default: ;
        endcase
        r.running_pid = m_run_ok ? m_ident[m_run] : 32'd0;
        return r;
    endfunction

    function automatic int pick_gap();
        int d;
        d = $urandom_range(0, 99);
        if (d < 40) return 0;
        if (d < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    // pid that is mostly a plausible live or recent identifier
    function automatic logic [31:0] pick_pid();
        int d;
        d = $urandom_range(0, 9);
        if (d < 7) return (m_next > 24) ? m_next - $urandom_range(1, 24)
                                         : $urandom_range(0, 24);
        if (d < 8) return 32'd0;
        return $urandom;
    endfunction

    function automatic void push_word(logic [2:0] k, logic [31:0] p, int g);
        t_cmd c;
        c.kind = k;
        c.pid = p;
        cmd_q.push_back(c);
        gap_q.push_back(g);
    endfunction

    // driver: one word per handshake, random gaps, a drain marker (-1)
    int   drv_wait = 0;
    logic drv_hold = 1'b0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                rsp_q.push_back(sched_apply(i_cmd));
                n_kind[i_cmd.kind]++;
                n_words++;
                start <= 1'b0;
                drv_wait = 0;
            end else if (!start) begin
                if (drv_hold) begin
                    if (rsp_q.size() == 0) drv_hold = 1'b0;
                end else if (drv_wait > 0) begin
                    drv_wait--;
                end else if (gap_q.size() > 0 && gap_q[0] < 0) begin
                    void'(gap_q.pop_front());
                    void'(cmd_q.pop_front());
                    drv_hold = 1'b1;
                end else if (cmd_q.size() > 0) begin
                    drv_wait = gap_q.pop_front();
                    if (drv_wait == 0) begin
                        i_cmd <= cmd_q.pop_front();
                        start <= 1'b1;
                    end else begin
                        drv_wait--;
                        gap_q.push_front(0);
                    end
                end
            end
        end
    end

    // monitor: compare each response word with the oldest prediction
    t_rsp exp_w;
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            n_done++;
            if (rsp_q.size() == 0) begin
                $display("%0t: unexpected word exp none act %h", $time, o_rsp);
                n_err++;
            end else begin
                exp_w = rsp_q.pop_front();
                if (o_rsp.status !== exp_w.status) begin
                    $display("%0t: status exp %0d act %0d", $time,
                             exp_w.status, o_rsp.status);
                    n_err++;
                end
                if (o_rsp.result_pid !== exp_w.result_pid) begin
                    $display("%0t: result_pid exp %h act %h", $time,
                             exp_w.result_pid, o_rsp.result_pid);
                    n_err++;
                end
                if (o_rsp.alive !== exp_w.alive) begin
                    $display("%0t: alive exp %b act %b", $time, exp_w.alive, o_rsp.alive);
                    n_err++;
                end
                if (o_rsp.running_pid !== exp_w.running_pid) begin
                    $display("%0t: running_pid exp %h act %h", $time,
                             exp_w.running_pid, o_rsp.running_pid);
                    n_err++;
                end
            end
        end
    end

    // watchdog on cycles without a handshake or a response
    int idle_cyc = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG_LIMIT) begin
            $display("watchdog expired");
            $display("FAIL");
            $finish;
        end
    end

    // stimulus: directed words, then random sequences
    logic [2:0] rk;
    initial begin
        sched_reset();
        for (int i = 0; i < 8; i++) n_kind[i] = 0;
        // empty table corner cases
        push_word(K_SWITCH, 32'd0, 0);
        push_word(K_EXIT, 32'd0, 0);
        push_word(K_REQUEUE, 32'd0, 0);
        push_word(K_KILL, 32'd0, 0);
        push_word(K_KILL, 32'hFFFF_FFFF, 1);
        push_word(K_QUERY, 32'd0, 0);
        // fill past capacity to see table full
        for (int i = 0; i < 17; i++) push_word(K_CREATE, $urandom, 0);
        push_word(K_SWITCH, 32'd0, 0);
        push_word(K_REQUEUE, 32'd0, 0);
        push_word(3'd6, 32'hFFFF_FFFF, 0);
        push_word(3'd7, 32'h5555_5555, 0);
        push_word(K_SWITCH, 32'd0, 0);
        push_word(K_KILL, 32'd5, 0);
        push_word(K_KILL, 32'd5, 0);
        push_word(K_QUERY, 32'd5, 0);
        push_word(K_QUERY, 32'd2, 0);
        push_word(K_KILL, 32'd2, 0);
        push_word(K_EXIT, 32'd0, 0);
        push_word(K_SWITCH, 32'hAAAA_AAAA, 0);
        push_word(K_CREATE, 32'd0, -1);

        // random part: kinds and gaps are drawn up front, with a drain marker every 250 words
        for (int n = 0; n < 1000; n++) begin
            rk = 3'($urandom_range(0, 99) < 4 ? $urandom_range(6, 7)
                                              : $urandom_range(0, 5));
            if (n % 250 == 249) push_word(K_SWITCH, 32'd0, -1);
            push_word(rk, 32'd0, pick_gap());
        end

        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // patch random pids just before issue so they track issued identifiers
        while (cmd_q.size() > 0 || start || drv_hold) begin
            @(negedge i_clk);
            if (cmd_q.size() > 25 && cmd_q.size() <= 1000 &&
                (cmd_q[0].kind == K_KILL || cmd_q[0].kind == K_QUERY) &&
                cmd_q[0].pid == 0)
                cmd_q[0].pid = pick_pid();
        end
        while (rsp_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d words issued, %0d responses; create %0d kill %0d exit %0d",
                 n_words, n_done, n_kind[0], n_kind[1], n_kind[2]);
        $display("switch %0d query %0d requeue %0d undefined kinds %0d",
                 n_kind[3], n_kind[4], n_kind[5], n_kind[6] + n_kind[7]);
        if (n_err == 0 && rsp_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ttrq_pkg.sv
rtl/ttrq_ctrl.sv
rtl/ttrq_dp.sv
rtl/task_table_ready_queue.sv
dv/tb_task_table_ready_queue.sv
